// ===== design/cfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_pkg
// shared types and constants for the circular fifo queue
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int CFG_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_OFFER   = 3'd0,
        OP_POLL    = 3'd1,
        OP_PEEK    = 3'd2,
        OP_PEEK_AT = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;

endpackage

// ===== design/cfq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_req_if / cfq_rsp_if
// valid/ready channels for queue operations and their results
// ----------------------------------------------------------------------------
interface cfq_req_if;
    import cfq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [DATA_WIDTH-1:0] value;
    logic [PTR_W-1:0]    position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface cfq_rsp_if;
    import cfq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [DATA_WIDTH-1:0] read_value;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
    logic                  is_full;

    modport source (output valid, output ok, output read_value, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    input is_empty, input is_full, output ready);
endinterface

// ===== design/circular_fifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_queue
// ring-buffer fifo with offer, poll, peek, peek-at-index and clear operations
// ----------------------------------------------------------------------------
// usage:
//   i_req carries one operation per transaction (operation, value, position);
//   o_rsp returns exactly one result transaction per request, in order, with
//   ok, read_value, count, is_empty and is_full after the operation.
//   i_cfg_we/i_cfg_wdata set the ring capacity (0 acts as 1, above the built
//   depth acts as the depth); a capacity write also empties the queue.
// pipeline and throughput:
//   a request is decided in the cycle it is accepted (pointers, count, ram
//   write or ram read); the result then passes through the pending stage,
//   which waits for the registered ram read data, and the output register.
//   one request per cycle is accepted as long as results are taken; the
//   figure is set by the single ram read port, at most one read per transaction.
// reset:
//   pointers and count go to zero, capacity to the built depth, no result is
//   pending; ram contents are not cleared, only written entries are read.
// stall:
//   while o_rsp is held, one more result waits in the pending stage and then
//   i_req.ready drops until the output register drains.
// ----------------------------------------------------------------------------
module circular_fifo_queue
    import cfq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    cfq_req_if.sink          i_req,
    cfq_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // queue state
    t_ptr r_wptr, n_wptr;
    t_ptr r_rptr, n_rptr;
    t_cnt r_count, n_count;
    t_cnt r_capacity, n_capacity;

    // pending stage: status decided at accept, waits for the ram read data
    logic r_busy;
    logic r_pend_ok;
    logic r_pend_rd;
    t_cnt r_pend_count;
    logic r_pend_empty;
    logic r_pend_full;

    // output register
    logic  r_rsp_valid;
    logic  r_rsp_ok;
    t_data r_rsp_value;
    t_cnt  r_rsp_count;
    logic  r_rsp_empty;
    logic  r_rsp_full;

    logic  accept;
    logic  move;
    logic  op_ok;
    logic  op_rd;
    logic  ram_we;
    logic  ram_re;
    t_ptr  ram_raddr;
    t_data ram_rdata;
    t_cnt  wnext;
    t_cnt  rnext;
    t_cnt  idx_sum;
    t_cnt  idx_wrap;
    t_cnt  cfg_cap;

    // pending result moves out when the output register is free or draining
    assign move        = r_busy && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = !r_busy || move;
    assign accept      = i_req.valid && i_req.ready;

    // pointer advance with wrap at capacity
    assign wnext = (CNT_W'(r_wptr) + 1'b1 >= r_capacity) ? '0 : CNT_W'(r_wptr) + 1'b1;
    assign rnext = (CNT_W'(r_rptr) + 1'b1 >= r_capacity) ? '0 : CNT_W'(r_rptr) + 1'b1;

    // k-th oldest: read pointer plus offset, one wrap at most
    assign idx_sum  = CNT_W'(r_rptr) + CNT_W'(i_req.position);
    assign idx_wrap = (idx_sum >= r_capacity) ? idx_sum - r_capacity : idx_sum;

    // capacity clamp on a config write
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (CNT_W'(i_cfg_wdata) > CNT_W'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = CNT_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_count    = r_count;
        n_capacity = r_capacity;
        op_ok      = 1'b0;
        op_rd      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_rptr;

        if (i_cfg_we) begin
            n_capacity = cfg_cap;
            n_wptr     = '0;
            n_rptr     = '0;
            n_count    = '0;
        end else if (accept) begin
            case (t_op'(i_req.operation))
                OP_OFFER: begin
                    if (r_count != r_capacity) begin
                        ram_we  = 1'b1;
                        n_wptr  = wnext[PTR_W-1:0];
                        n_count = r_count + 1'b1;
                        op_ok   = 1'b1;
                    end
                end
                OP_POLL: begin
                    if (r_count != '0) begin
                        ram_re  = 1'b1;
                        n_rptr  = rnext[PTR_W-1:0];
                        n_count = r_count - 1'b1;
                        op_ok   = 1'b1;
                        op_rd   = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (r_count != '0) begin
                        ram_re = 1'b1;
                        op_ok  = 1'b1;
                        op_rd  = 1'b1;
                    end
                end
                OP_PEEK_AT: begin
                    if (CNT_W'(i_req.position) < r_count) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_wrap[PTR_W-1:0];
                        op_ok     = 1'b1;
                        op_rd     = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_wptr  = '0;
                    n_rptr  = '0;
                    n_count = '0;
                    op_ok   = 1'b1;
                end
                default: begin
                    // undefined codes leave the queue untouched
                end
            endcase
        end
    end

    cfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (i_req.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_capacity  <= CNT_W'(DEPTH);
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_wptr     <= n_wptr;
            r_rptr     <= n_rptr;
            r_count    <= n_count;
            r_capacity <= n_capacity;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (move) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload of the pending stage and the output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_ok    <= op_ok;
            r_pend_rd    <= op_rd;
            r_pend_count <= n_count;
            r_pend_empty <= (n_count == '0);
            r_pend_full  <= (n_count == r_capacity);
        end
        if (move) begin
            r_rsp_ok    <= r_pend_ok;
            r_rsp_value <= r_pend_rd ? ram_rdata : '0;
            r_rsp_count <= r_pend_count;
            r_rsp_empty <= r_pend_empty;
            r_rsp_full  <= r_pend_full;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.ok         = r_rsp_ok;
    assign o_rsp.read_value = r_rsp_value;
    assign o_rsp.count      = r_rsp_count;
    assign o_rsp.is_empty   = r_rsp_empty;
    assign o_rsp.is_full    = r_rsp_full;

endmodule

// ===== design/cfq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_circular_fifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue
// self-checking bench for the circular fifo queue: a behavioral ring model
// predicts every result transaction, a random-stall sink compares it field by
// field; directed corner cases come first, then long random traffic that
// swings between filling and draining under several capacity settings
// ----------------------------------------------------------------------------
module tb_circular_fifo_queue;
    import cfq_pkg::*;

    localparam int               CLK_HALF       = 5;
    localparam int               MAX_IDLE       = 17;
    localparam int               DRAIN_CYCLES   = 8;
    localparam int               RANDOM_OPS     = 900;
    localparam int               RANDOM_PHASES  = 8;
    localparam logic [OP_W-1:0]  OP_UNDEF_FIRST = 3'd5;
    localparam logic [OP_W-1:0]  OP_UNDEF_LAST  = 3'd7;
    localparam logic [CFG_W-1:0] CAP_BELOW_MIN  = 5'd0;
    localparam logic [CFG_W-1:0] CAP_ABOVE_MAX  = 5'd31;

    typedef struct packed {
        logic  ok;
        t_data read_value;
        t_cnt  count;
        logic  is_empty;
        logic  is_full;
    } t_status;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    cfq_req_if req_if ();
    cfq_rsp_if rsp_if ();

    circular_fifo_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // ring model state
    t_data   ring_store [DEPTH];
    int      ring_wr_ptr;
    int      ring_rd_ptr;
    int      ring_capacity;
    bit      ring_empty;

    t_status expected_results [$];
    int      error_count  = 0;
    int      src_max_idle = 0;
    int      snk_max_idle = 0;

    // ------------------------------------------------------------------------
    // ring model
    // ------------------------------------------------------------------------
    function automatic void ring_clear();
        ring_wr_ptr = 0;
        ring_rd_ptr = 0;
        ring_empty  = 1'b1;
    endfunction

    function automatic int ring_next(int p);
        return (p + 1 >= ring_capacity) ? 0 : p + 1;
    endfunction

    function automatic int ring_count();
        if (ring_empty)
            return 0;
        if (ring_wr_ptr == ring_rd_ptr)
            return ring_capacity;
        if (ring_wr_ptr > ring_rd_ptr)
            return ring_wr_ptr - ring_rd_ptr;
        return ring_capacity - ring_rd_ptr + ring_wr_ptr;
    endfunction

    // applies one operation to the ring and returns the status it reports
    function automatic t_status apply_queue_op(logic [OP_W-1:0] op, t_data val, t_ptr pos);
        t_status st;
        int      idx;
        st = '0;
        case (op)
            OP_OFFER: begin
                if (ring_empty || ring_wr_ptr != ring_rd_ptr) begin
                    ring_store[ring_wr_ptr] = val;
                    ring_wr_ptr = ring_next(ring_wr_ptr);
                    ring_empty  = 1'b0;
                    st.ok       = 1'b1;
                end
            end
            OP_POLL: begin
                if (!ring_empty) begin
                    st.read_value = ring_store[ring_rd_ptr];
                    ring_rd_ptr   = ring_next(ring_rd_ptr);
                    if (ring_rd_ptr == ring_wr_ptr)
                        ring_empty = 1'b1;
                    st.ok = 1'b1;
                end
            end
            OP_PEEK: begin
                if (!ring_empty) begin
                    st.read_value = ring_store[ring_rd_ptr];
                    st.ok         = 1'b1;
                end
            end
            OP_PEEK_AT: begin
                if (int'(pos) < ring_count()) begin
                    idx = ring_rd_ptr + int'(pos);
                    if (idx >= ring_capacity)
                        idx -= ring_capacity;
                    st.read_value = ring_store[idx];
                    st.ok         = 1'b1;
                end
            end
            OP_CLEAR: begin
                ring_clear();
                st.ok = 1'b1;
            end
            default: ;
        endcase
        st.count    = t_cnt'(ring_count());
        st.is_empty = ring_empty;
        st.is_full  = (ring_count() == ring_capacity);
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // returns at the falling edge after acceptance with valid still high, so a
    // back-to-back transaction keeps valid up without a second assignment
    task automatic send_op(logic [OP_W-1:0] op, t_data val, t_ptr pos);
        int idle;
        idle = $urandom_range(0, src_max_idle);
        if (idle != 0) begin
            req_if.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= val;
        req_if.position  <= pos;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        expected_results.push_back(apply_queue_op(op, val, pos));
        @(negedge clk);
    endtask

    // stop issuing and let every outstanding result come back
    task automatic settle_queue();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        settle_queue();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (cap == 0)
            ring_capacity = 1;
        else if (cap > DEPTH)
            ring_capacity = DEPTH;
        else
            ring_capacity = cap;
        ring_clear();
    endtask

    function automatic int pick_idle_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 2;
            default: return MAX_IDLE;
        endcase
    endfunction

    // one random operation, weighted toward filling or draining the ring
    task automatic send_random_op(bit fill_bias);
        int              roll;
        int              cnt;
        logic [OP_W-1:0] op;
        t_data           val;
        t_ptr            pos;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = OP_W'(OP_UNDEF_FIRST + $urandom_range(0, OP_UNDEF_LAST - OP_UNDEF_FIRST));
        else if (roll < 3)
            op = OP_CLEAR;
        else if (roll < 58)
            op = fill_bias ? OP_OFFER : OP_POLL;
        else if (roll < 78)
            op = fill_bias ? OP_POLL : OP_OFFER;
        else if (roll < 88)
            op = OP_PEEK;
        else
            op = OP_PEEK_AT;
        case ($urandom_range(0, 9))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom;
        endcase
        // mostly positions that can hit, the rest anywhere in the field
        cnt = ring_count();
        if ($urandom_range(0, 9) < 7)
            pos = t_ptr'($urandom_range(0, (cnt < DEPTH) ? cnt : DEPTH - 1));
        else
            pos = t_ptr'($urandom_range(0, DEPTH - 1));
        send_op(op, val, pos);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [DATA_WIDTH-1:0] want,
                                        logic [DATA_WIDTH-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    initial begin : result_checker
        t_status want;
        int      stall;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, snk_max_idle);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (rsp_if.valid !== 1'b1);
            if (expected_results.size() == 0) begin
                $error("result transaction with no operation outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("ok", want.ok, rsp_if.ok);
                check_field("read_value", want.read_value, rsp_if.read_value);
                check_field("count", want.count, rsp_if.count);
                check_field("is_empty", want.is_empty, rsp_if.is_empty);
                check_field("is_full", want.is_full, rsp_if.is_full);
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // fresh queue at full depth: every read fails, clear and unknown codes
    task automatic test_empty_queue();
        src_max_idle = 0;
        snk_max_idle = 3;
        send_op(OP_POLL, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_PEEK_AT, '0, '0);
        send_op(OP_PEEK_AT, '0, '1);
        for (int k = OP_UNDEF_FIRST; k <= OP_UNDEF_LAST; k++)
            send_op(k[OP_W-1:0], '1, '1);
        send_op(OP_CLEAR, '0, '0);
    endtask

    // capacity written as zero acts as a single-entry ring
    task automatic test_single_entry_ring();
        write_capacity(CAP_BELOW_MIN);
        src_max_idle = 2;
        snk_max_idle = 0;
        send_op(OP_OFFER, '0, '0);
        send_op(OP_OFFER, '1, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_PEEK_AT, '0, '0);
        send_op(OP_PEEK_AT, '0, t_ptr'(1));
        send_op(OP_POLL, '0, '0);
        send_op(OP_POLL, '0, '0);
    endtask

    // two-entry ring: full refusal, wrap of the write pointer, indexed peek
    task automatic test_two_entry_wrap();
        write_capacity(5'd2);
        src_max_idle = MAX_IDLE;
        snk_max_idle = MAX_IDLE;
        send_op(OP_OFFER, 32'hA5A5_0001, '0);
        send_op(OP_OFFER, 32'h5A5A_0002, '0);
        send_op(OP_OFFER, 32'hDEAD_0003, '0);
        send_op(OP_POLL, '0, '0);
        send_op(OP_OFFER, 32'hBEEF_0004, '0);
        send_op(OP_PEEK_AT, '0, t_ptr'(1));
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_PEEK, '0, '0);
    endtask

    // random traffic over several capacities, alternating fill and drain runs
    task automatic test_random_traffic();
        logic [CFG_W-1:0] phase_caps [6] = '{CAP_ABOVE_MAX, 5'd1, 5'd2, 5'd7,
                                             CAP_BELOW_MIN, 5'(DEPTH)};
        logic [CFG_W-1:0] cap;
        bit               fill_bias;
        int               run_left;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cap = (phase < 6) ? phase_caps[phase] : CFG_W'($urandom_range(0, 31));
            write_capacity(cap);
            src_max_idle = pick_idle_limit();
            snk_max_idle = pick_idle_limit();
            fill_bias    = 1'b1;
            run_left     = $urandom_range(8, 40);
            for (int n = 0; n < RANDOM_OPS / RANDOM_PHASES; n++) begin
                if (run_left == 0) begin
                    fill_bias    = ~fill_bias;
                    run_left     = $urandom_range(8, 40);
                    src_max_idle = pick_idle_limit();
                    snk_max_idle = pick_idle_limit();
                end
                run_left--;
                send_random_op(fill_bias);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        req_if.valid     = 1'b0;
        req_if.operation = '0;
        req_if.value     = '0;
        req_if.position  = '0;
        ring_capacity    = DEPTH;
        ring_clear();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_queue();
        test_single_entry_ring();
        test_two_entry_wrap();
        test_random_traffic();
        settle_queue();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
